// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/nnaf_pkg.sv =====
// Types and constants of the missing-cell neighbor average fill.
package nnaf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned PEND_DEPTH = MAX_WIDTH + 1;
  localparam int unsigned PTR_W      = $clog2(PEND_DEPTH);
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned WCNT_W     = $clog2(MAX_WIDTH + 2);

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned MAG_W  = 34;
  localparam int unsigned NCNT_W = 3;
  localparam int unsigned GW_W   = 11;
  localparam int unsigned GH_W   = 16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = 16'd1;

  localparam int unsigned      DIV3_SHIFT = 34;
  localparam logic [MAG_W-1:0] DIV3_MUL   = 34'h155555556;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             miss;
    logic [VAL_W-1:0] value;
  } cell_t;

endpackage

// ===== sv/nnaf_in_if.sv =====
// Input sample channel.
interface nnaf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [nnaf_pkg::VAL_W-1:0] sample_value;
  logic                              sample_missing;
  logic                              padding;

  modport source (output valid, sample_value, sample_missing, padding, input ready);
  modport sink   (input valid, sample_value, sample_missing, padding, output ready);
endinterface

// ===== sv/nnaf_out_if.sv =====
// Output cell channel.
interface nnaf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [nnaf_pkg::VAL_W-1:0] out_value;
  logic                              out_missing;
  logic                              out_last;

  modport source (output valid, out_value, out_missing, out_last, input ready);
  modport sink   (input valid, out_value, out_missing, out_last, output ready);
endinterface

// ===== sv/nodata_neighbor_average_fill.sv =====
// Top level of the missing-cell neighbor average fill.
// A cell leaves after the transfer that lies width+1 items behind it, through the read,
// sum, magnitude, reciprocal multiply and write-back steps; write-back waits while the
// output is held, and no new item is taken until it is done. Fill-only items go in idle.
// Reset: asynchronous, active low; clears the frame position and output valid, the
// delay-line and row memories are not cleared and need no clearing pass.
`include "assert_macros.svh"

module nodata_neighbor_average_fill (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  nnaf_in_if.sink                             sample_i,
  nnaf_out_if.source                          result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nnaf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nnaf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nnaf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MAG,
    S_MUL,
    S_OUT
  } state_e;

  function automatic logic [nnaf_pkg::PTR_W-1:0] ptr_inc(
    input logic [nnaf_pkg::PTR_W-1:0] p
  );
    return (p == nnaf_pkg::PTR_W'(nnaf_pkg::PEND_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  nnaf_pkg::cell_t pend_mem [nnaf_pkg::PEND_DEPTH];
  nnaf_pkg::cell_t rep_mem  [nnaf_pkg::MAX_WIDTH];

  state_e                          state_q, state_d;
  logic [nnaf_pkg::GW_W-1:0]       gw_q, gw_d;
  logic [nnaf_pkg::GH_W-1:0]       gh_q, gh_d;
  logic [nnaf_pkg::WCNT_W-1:0]     fill_q, fill_d;
  logic [nnaf_pkg::COL_W-1:0]      col_q, col_d;
  logic [nnaf_pkg::GH_W-1:0]       row_q, row_d;
  logic [nnaf_pkg::PTR_W-1:0]      wp_q, wp_d;
  logic [nnaf_pkg::PTR_W-1:0]      rp_q, rp_d;
  nnaf_pkg::cell_t                 below_q, below_d;
  nnaf_pkg::cell_t                 inc_q, inc_d;
  nnaf_pkg::cell_t                 left_q, left_d;
  nnaf_pkg::cell_t                 cur_q, cur_d;
  logic                            has_left_q, has_left_d;
  logic                            has_right_q, has_right_d;
  logic                            has_up_q, has_up_d;
  logic                            has_down_q, has_down_d;
  logic                            last_q, last_d;
  logic                            last_col_q, last_col_d;
  logic signed [nnaf_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [nnaf_pkg::NCNT_W-1:0]     ncnt_q, ncnt_d;
  logic                            neg_q, neg_d;
  logic [nnaf_pkg::MAG_W-1:0]      mag_q, mag_d;
  logic [nnaf_pkg::VAL_W-1:0]      q3_q, q3_d;
  logic                            out_valid_q, out_valid_d;
  nnaf_pkg::cell_t                 out_cell_q, out_cell_d;
  logic                            out_last_q, out_last_d;

  nnaf_pkg::cell_t                 pend_rd0_q, pend_rd1_q, rep_rd_q;

  logic [nnaf_pkg::WCNT_W-1:0]     act_w;
  logic [nnaf_pkg::GH_W-1:0]       act_h;
  logic                            cfg_we;
  nnaf_pkg::reg_idx_e              cfg_idx;
  logic                            in_xfer;
  nnaf_pkg::cell_t                 incoming;
  logic                            pend_we;
  logic                            rd_en;
  logic                            rep_we;
  nnaf_pkg::cell_t                 result;
  logic [nnaf_pkg::VAL_W-1:0]      quot;
  logic [nnaf_pkg::VAL_W-1:0]      avg;
  logic [2*nnaf_pkg::MAG_W-1:0]    prod;
  logic signed [nnaf_pkg::SUM_W-1:0] t_left, t_right, t_up, t_down;
  logic                            k_left, k_right, k_up, k_down;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = nnaf_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      nnaf_pkg::REG_GRID_WIDTH:  prdata = nnaf_pkg::APB_DATA_W'(gw_q);
      nnaf_pkg::REG_GRID_HEIGHT: prdata = nnaf_pkg::APB_DATA_W'(gh_q);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    if (gw_q == '0) begin
      act_w = nnaf_pkg::WCNT_W'(1);
    end else if (32'(gw_q) > nnaf_pkg::MAX_WIDTH) begin
      act_w = nnaf_pkg::WCNT_W'(nnaf_pkg::MAX_WIDTH);
    end else begin
      act_w = nnaf_pkg::WCNT_W'(gw_q);
    end
    act_h = (gh_q == '0) ? nnaf_pkg::GH_W'(1) : gh_q;
  end

  assign sample_i.ready     = (state_q == S_IDLE);
  assign in_xfer            = sample_i.valid & sample_i.ready;
  assign incoming.miss      = sample_i.padding | sample_i.sample_missing;
  assign incoming.value     = sample_i.padding ? '0 : sample_i.sample_value;

  assign result_o.valid       = out_valid_q;
  assign result_o.out_value   = out_cell_q.value;
  assign result_o.out_missing = out_cell_q.miss;
  assign result_o.out_last    = out_last_q;

  assign k_left  = has_left_q  & ~left_q.miss;
  assign k_right = has_right_q & ~pend_rd1_q.miss;
  assign k_up    = has_up_q    & ~rep_rd_q.miss;
  assign k_down  = has_down_q  & ~below_q.miss;
  assign t_left  = k_left  ? nnaf_pkg::SUM_W'($signed(left_q.value))     : '0;
  assign t_right = k_right ? nnaf_pkg::SUM_W'($signed(pend_rd1_q.value)) : '0;
  assign t_up    = k_up    ? nnaf_pkg::SUM_W'($signed(rep_rd_q.value))   : '0;
  assign t_down  = k_down  ? nnaf_pkg::SUM_W'($signed(below_q.value))    : '0;

  assign prod = (2*nnaf_pkg::MAG_W)'(mag_q) * (2*nnaf_pkg::MAG_W)'(nnaf_pkg::DIV3_MUL);

  always_comb begin
    case (ncnt_q)
      3'd1:    quot = mag_q[nnaf_pkg::VAL_W-1:0];
      3'd2:    quot = mag_q[nnaf_pkg::VAL_W:1];
      3'd3:    quot = q3_q;
      3'd4:    quot = mag_q[nnaf_pkg::VAL_W+1:2];
      default: quot = '0;
    endcase
    avg = neg_q ? (~quot + 1'b1) : quot;
    if (!cur_q.miss) begin
      result = cur_q;
    end else if (ncnt_q == '0) begin
      result.miss  = 1'b1;
      result.value = '0;
    end else begin
      result.miss  = 1'b0;
      result.value = avg;
    end
  end

  always_comb begin
    state_d     = state_q;
    gw_d        = gw_q;
    gh_d        = gh_q;
    fill_d      = fill_q;
    col_d       = col_q;
    row_d       = row_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    below_d     = below_q;
    inc_d       = inc_q;
    left_d      = left_q;
    cur_d       = cur_q;
    has_left_d  = has_left_q;
    has_right_d = has_right_q;
    has_up_d    = has_up_q;
    has_down_d  = has_down_q;
    last_d      = last_q;
    last_col_d  = last_col_q;
    sum_d       = sum_q;
    ncnt_d      = ncnt_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    q3_d        = q3_q;
    out_cell_d  = out_cell_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~result_o.ready;
    pend_we     = 1'b0;
    rd_en       = 1'b0;
    rep_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (fill_q == '0 && sample_i.padding) begin
            fill_d = fill_q;
          end else if (fill_q <= act_w) begin
            pend_we = 1'b1;
            wp_d    = ptr_inc(wp_q);
            fill_d  = fill_q + 1'b1;
            below_d = incoming;
          end else begin
            rd_en       = 1'b1;
            inc_d       = incoming;
            has_left_d  = (col_q != '0);
            has_right_d = (nnaf_pkg::WCNT_W'(col_q) + 1'b1) < act_w;
            has_up_d    = (row_q != '0);
            has_down_d  = ({1'b0, row_q} + 1'b1) < {1'b0, act_h};
            last_col_d  = (nnaf_pkg::WCNT_W'(col_q) + 1'b1) >= act_w;
            last_d      = ~has_down_d & last_col_d;
            if (!last_d) begin
              pend_we = 1'b1;
              wp_d    = ptr_inc(wp_q);
            end
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        cur_d   = pend_rd0_q;
        sum_d   = t_left + t_right + t_up + t_down;
        ncnt_d  = nnaf_pkg::NCNT_W'(k_left) + nnaf_pkg::NCNT_W'(k_right)
                + nnaf_pkg::NCNT_W'(k_up) + nnaf_pkg::NCNT_W'(k_down);
        below_d = inc_q;
        state_d = S_MAG;
      end
      S_MAG: begin
        neg_d   = sum_q[nnaf_pkg::SUM_W-1];
        mag_d   = nnaf_pkg::MAG_W'(sum_q[nnaf_pkg::SUM_W-1] ? -sum_q : sum_q);
        state_d = S_MUL;
      end
      S_MUL: begin
        q3_d    = prod[nnaf_pkg::DIV3_SHIFT +: nnaf_pkg::VAL_W];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          rep_we      = 1'b1;
          left_d      = result;
          out_valid_d = 1'b1;
          out_cell_d  = result;
          out_last_d  = last_q;
          state_d     = S_IDLE;
          if (last_q) begin
            fill_d = '0;
            col_d  = '0;
            row_d  = '0;
            wp_d   = '0;
            rp_d   = '0;
          end else begin
            rp_d = ptr_inc(rp_q);
            if (last_col_q) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_idx)
        nnaf_pkg::REG_GRID_WIDTH:  gw_d = pwdata[nnaf_pkg::GW_W-1:0];
        nnaf_pkg::REG_GRID_HEIGHT: gh_d = pwdata[nnaf_pkg::GH_W-1:0];
        default:                   gw_d = gw_q;
      endcase
      fill_d  = '0;
      col_d   = '0;
      row_d   = '0;
      wp_d    = '0;
      rp_d    = '0;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gw_q        <= nnaf_pkg::GRID_WIDTH_RESET;
      gh_q        <= nnaf_pkg::GRID_HEIGHT_RESET;
      fill_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gw_q        <= gw_d;
      gh_q        <= gh_d;
      fill_q      <= fill_d;
      col_q       <= col_d;
      row_q       <= row_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q     <= below_d;
    inc_q       <= inc_d;
    left_q      <= left_d;
    cur_q       <= cur_d;
    has_left_q  <= has_left_d;
    has_right_q <= has_right_d;
    has_up_q    <= has_up_d;
    has_down_q  <= has_down_d;
    last_q      <= last_d;
    last_col_q  <= last_col_d;
    sum_q       <= sum_d;
    ncnt_q      <= ncnt_d;
    neg_q       <= neg_d;
    mag_q       <= mag_d;
    q3_q        <= q3_d;
    out_cell_q  <= out_cell_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[wp_q] <= incoming;
    end
    if (rd_en) begin
      pend_rd0_q <= pend_mem[rp_q];
      pend_rd1_q <= pend_mem[ptr_inc(rp_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_we) begin
      rep_mem[col_q] <= result;
    end
    if (rd_en) begin
      rep_rd_q <= rep_mem[col_q];
    end
  end

  `ASSERT_CLK(a_fill_bound, clk_i, rst_ni, {1'b0, fill_q} <= ({1'b0, act_w} + 1'b1), "fill count beyond width+1")
  `ASSERT_CLK(a_emit_when_full, clk_i, rst_ni, (state_q != S_IDLE) |-> (fill_q > act_w), "emission with delay line not full")
  `ASSERT_CLK(a_out_from_writeback, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_OUT), "output loaded outside write-back")
  `ASSERT_NEVER(a_col_range, clk_i, rst_ni, nnaf_pkg::WCNT_W'(col_q) >= act_w, "emit column outside grid")

endmodule
